// ===== rtl/alcp_pkg.sv =====
// types, constants and helper functions shared by the command parser modules
package alcp_pkg;

    localparam int LINE_CAP     = 255;
    localparam int NAME_MAX     = 63;
    localparam int CHUNK_ID_MAX = 65535;

    localparam int LEN_W   = $clog2(LINE_CAP + 1);
    localparam int NAME_W  = $clog2(NAME_MAX + 1);
    localparam int MAG_W   = $clog2(CHUNK_ID_MAX * 10 + 10);
    localparam int CHUNK_W = 17;
    localparam int BYTE_W  = 8;

    localparam int TOK_BANKS = 2;
    localparam int TOK_AW    = NAME_W + $clog2(TOK_BANKS);
    localparam int TOK_DEPTH = TOK_BANKS * (2 ** NAME_W);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam int READ_LEN  = 5;
    localparam int CHUNK_LEN = 10;
    localparam int END_LEN   = 7;

    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_CHUNK = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TK_SKIP,
        TK_NAME,
        TK_DONE
    } t_tok_state;

    typedef enum logic [1:0] {
        NM_SKIP,
        NM_DIGIT,
        NM_DONE
    } t_num_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_SEND
    } t_back_state;

    typedef struct packed {
        t_kind             kind;
        logic [NAME_W-1:0] count;
        logic              bank;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [TOK_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_tok_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    function automatic logic f_is_space(input logic [BYTE_W-1:0] c);
        f_is_space = (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    function automatic logic f_is_digit(input logic [BYTE_W-1:0] c);
        f_is_digit = (c inside {[8'h30:8'h39]});
    endfunction

    // "READ "
    function automatic logic [BYTE_W-1:0] f_read_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0: c = 8'h52;
            3'd1: c = 8'h45;
            3'd2: c = 8'h41;
            3'd3: c = 8'h44;
            3'd4: c = 8'h20;
            default: c = 8'h00;
        endcase
        f_read_char = c;
    endfunction

    // "ACK CHUNK "
    function automatic logic [BYTE_W-1:0] f_chunk_char(input logic [3:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            4'd0: c = 8'h41;
            4'd1: c = 8'h43;
            4'd2: c = 8'h4B;
            4'd3: c = 8'h20;
            4'd4: c = 8'h43;
            4'd5: c = 8'h48;
            4'd6: c = 8'h55;
            4'd7: c = 8'h4E;
            4'd8: c = 8'h4B;
            4'd9: c = 8'h20;
            default: c = 8'h00;
        endcase
        f_chunk_char = c;
    endfunction

    // "ACK END"
    function automatic logic [BYTE_W-1:0] f_end_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0: c = 8'h41;
            3'd1: c = 8'h43;
            3'd2: c = 8'h4B;
            3'd3: c = 8'h20;
            3'd4: c = 8'h45;
            3'd5: c = 8'h4E;
            3'd6: c = 8'h44;
            default: c = 8'h00;
        endcase
        f_end_char = c;
    endfunction

endpackage

// ===== rtl/alcp_queue.sv =====
// short command queue between the line front end and the result back end
module alcp_queue
    import alcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;
    logic [Q_AW-1:0] n_wptr;
    logic [Q_AW-1:0] n_rptr;
    logic [Q_AW:0]   n_count;
    logic            do_push;
    logic            do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_head  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/alcp_front.sv =====
// front end: takes link bytes, matches the commands on the fly and queues line results
module alcp_front
    import alcp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    input  logic                i_q_full,
    input  t_release            i_release,
    output logic                o_push,
    output t_cmd                o_cmd,
    output t_tok_wr             o_tok_wr
);

    logic [LEN_W-1:0]          r_len;
    logic [LEN_W-1:0]          n_len;
    logic                      r_nul;
    logic                      n_nul;
    logic                      r_pre_read;
    logic                      n_pre_read;
    logic                      r_pre_chunk;
    logic                      n_pre_chunk;
    logic                      r_pre_end;
    logic                      n_pre_end;
    t_tok_state                r_tok_state;
    t_tok_state                n_tok_state;
    logic [NAME_W-1:0]         r_tcount;
    logic [NAME_W-1:0]         n_tcount;
    t_num_state                r_num_state;
    t_num_state                n_num_state;
    logic                      r_neg;
    logic                      n_neg;
    logic                      r_digit;
    logic                      n_digit;
    logic [MAG_W-1:0]          r_mag;
    logic [MAG_W-1:0]          n_mag;
    logic                      r_wbank;
    logic                      n_wbank;
    logic [TOK_BANKS-1:0]      r_busy;
    logic [TOK_BANKS-1:0]      n_busy;

    logic [BYTE_W-1:0]         c;
    logic signed [CHUNK_W-1:0] awaited;
    logic signed [CHUNK_W-1:0] value;
    logic [LEN_W-1:0]          clen;
    logic                      accept;
    logic                      is_eol;
    logic                      read_hit;
    logic                      chunk_hit;
    logic                      end_hit;

    assign c       = i_s_axis_tdata[BYTE_W-1:0];
    assign awaited = $signed(i_s_axis_tdata[BYTE_W+CHUNK_W-1:BYTE_W]);
    assign o_s_axis_tready = !i_q_full && !r_busy[r_wbank];
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign is_eol  = (c == CHAR_LF) || (c == CHAR_CR);
    assign clen    = r_len - LEN_W'(r_nul);

    always_comb begin
        value = $signed({1'b0, r_mag[CHUNK_W-2:0]});
        if (r_neg) begin
            value = -value;
        end
    end

    assign read_hit  = r_pre_read && (clen >= LEN_W'(READ_LEN)) && (r_tcount != '0);
    assign chunk_hit = r_pre_chunk && (clen >= LEN_W'(CHUNK_LEN)) && r_digit
                       && (r_mag <= MAG_W'(CHUNK_ID_MAX)) && (value == awaited);
    assign end_hit   = r_pre_end && (clen == LEN_W'(END_LEN));

    always_comb begin
        n_len       = r_len;
        n_nul       = r_nul;
        n_pre_read  = r_pre_read;
        n_pre_chunk = r_pre_chunk;
        n_pre_end   = r_pre_end;
        n_tok_state = r_tok_state;
        n_tcount    = r_tcount;
        n_num_state = r_num_state;
        n_neg       = r_neg;
        n_digit     = r_digit;
        n_mag       = r_mag;
        n_wbank     = r_wbank;
        n_busy      = r_busy;
        o_push      = 1'b0;
        o_cmd       = '{kind: KIND_NAME, count: r_tcount, bank: r_wbank};
        o_tok_wr    = '{en: 1'b0, addr: {r_wbank, r_tcount}, data: c};

        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end

        if (accept) begin
            if (is_eol) begin
                if (r_len != '0) begin
                    if (read_hit) begin
                        o_push            = 1'b1;
                        n_busy[r_wbank]   = 1'b1;
                        n_wbank           = !r_wbank;
                    end else if (chunk_hit) begin
                        o_push    = 1'b1;
                        o_cmd     = '{kind: KIND_CHUNK, count: '0, bank: r_wbank};
                    end else if (end_hit) begin
                        o_push    = 1'b1;
                        o_cmd     = '{kind: KIND_END, count: '0, bank: r_wbank};
                    end
                    n_len       = '0;
                    n_nul       = 1'b0;
                    n_pre_read  = 1'b1;
                    n_pre_chunk = 1'b1;
                    n_pre_end   = 1'b1;
                    n_tok_state = TK_SKIP;
                    n_tcount    = '0;
                    n_num_state = NM_SKIP;
                    n_neg       = 1'b0;
                    n_digit     = 1'b0;
                    n_mag       = '0;
                end
            end else if (!r_nul && (r_len < LEN_W'(LINE_CAP))) begin
                n_len = r_len + 1'b1;
                if (c == CHAR_NUL) begin
                    n_nul = 1'b1;
                end else begin
                    if (r_len < LEN_W'(READ_LEN)) begin
                        n_pre_read = r_pre_read && (c == f_read_char(r_len[2:0]));
                    end else if (r_pre_read) begin
                        case (r_tok_state)
                            TK_SKIP: begin
                                if (!f_is_space(c)) begin
                                    o_tok_wr.en = 1'b1;
                                    n_tcount    = r_tcount + 1'b1;
                                    n_tok_state = TK_NAME;
                                end
                            end
                            TK_NAME: begin
                                if (f_is_space(c)) begin
                                    n_tok_state = TK_DONE;
                                end else if (r_tcount < NAME_W'(NAME_MAX)) begin
                                    o_tok_wr.en = 1'b1;
                                    n_tcount    = r_tcount + 1'b1;
                                end else begin
                                    n_tok_state = TK_DONE;
                                end
                            end
                            default: begin
                                n_tok_state = TK_DONE;
                            end
                        endcase
                    end

                    if (r_len < LEN_W'(CHUNK_LEN)) begin
                        n_pre_chunk = r_pre_chunk && (c == f_chunk_char(r_len[3:0]));
                    end else if (r_pre_chunk) begin
                        case (r_num_state)
                            NM_SKIP: begin
                                if (f_is_space(c)) begin
                                    n_num_state = NM_SKIP;
                                end else if (c == CHAR_PLUS) begin
                                    n_num_state = NM_DIGIT;
                                end else if (c == CHAR_MINUS) begin
                                    n_neg       = 1'b1;
                                    n_num_state = NM_DIGIT;
                                end else if (f_is_digit(c)) begin
                                    n_digit     = 1'b1;
                                    n_mag       = MAG_W'(c[3:0]);
                                    n_num_state = NM_DIGIT;
                                end else begin
                                    n_num_state = NM_DONE;
                                end
                            end
                            NM_DIGIT: begin
                                if (f_is_digit(c)) begin
                                    n_digit = 1'b1;
                                    if (r_mag <= MAG_W'(CHUNK_ID_MAX)) begin
                                        // times ten as two shifts
                                        n_mag = MAG_W'({r_mag, 3'b000} + {2'b00, r_mag, 1'b0}
                                                       + (MAG_W + 3)'(c[3:0]));
                                    end
                                end else begin
                                    n_num_state = NM_DONE;
                                end
                            end
                            default: begin
                                n_num_state = NM_DONE;
                            end
                        endcase
                    end

                    if (r_len < LEN_W'(END_LEN)) begin
                        n_pre_end = r_pre_end && (c == f_end_char(r_len[2:0]));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_nul       <= 1'b0;
            r_pre_read  <= 1'b1;
            r_pre_chunk <= 1'b1;
            r_pre_end   <= 1'b1;
            r_tok_state <= TK_SKIP;
            r_tcount    <= '0;
            r_num_state <= NM_SKIP;
            r_neg       <= 1'b0;
            r_digit     <= 1'b0;
            r_wbank     <= 1'b0;
            r_busy      <= '0;
        end else begin
            r_len       <= n_len;
            r_nul       <= n_nul;
            r_pre_read  <= n_pre_read;
            r_pre_chunk <= n_pre_chunk;
            r_pre_end   <= n_pre_end;
            r_tok_state <= n_tok_state;
            r_tcount    <= n_tcount;
            r_num_state <= n_num_state;
            r_neg       <= n_neg;
            r_digit     <= n_digit;
            r_wbank     <= n_wbank;
            r_busy      <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= '0;
        end else begin
            r_mag <= n_mag;
        end
    end

endmodule

// ===== rtl/alcp_back.sv =====
// back end: holds the token store and sends the result items of each queued command
module alcp_back
    import alcp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_head,
    input  logic                i_empty,
    output logic                o_pop,
    input  t_tok_wr             i_tok_wr,
    output t_release            o_release,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]          o_m_axis_tuser,
    output logic                o_m_axis_tlast
);

    logic [BYTE_W-1:0] r_tok_mem [TOK_DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    t_back_state       r_state;
    t_back_state       n_state;
    t_cmd              r_entry;
    t_cmd              n_entry;
    logic [NAME_W-1:0] r_idx;
    logic [NAME_W-1:0] n_idx;
    logic              is_name;
    logic              last_item;

    assign is_name   = (r_entry.kind == KIND_NAME);
    assign last_item = !is_name || (r_idx == r_entry.count - 1'b1);

    always_comb begin
        n_state   = r_state;
        n_entry   = r_entry;
        n_idx     = r_idx;
        o_pop     = 1'b0;
        o_release = '0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_entry = i_head;
                    n_idx   = '0;
                    n_state = (i_head.kind == KIND_NAME) ? BK_FETCH : BK_SEND;
                end
            end
            BK_FETCH: begin
                n_state = BK_SEND;
            end
            BK_SEND: begin
                if (i_m_axis_tready) begin
                    if (!last_item) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = BK_FETCH;
                    end else begin
                        o_release.valid = is_name;
                        o_release.bank  = r_entry.bank;
                        n_state         = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_idx   <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_wr.en) begin
            r_tok_mem[i_tok_wr.addr] <= i_tok_wr.data;
        end
        if (r_state == BK_FETCH) begin
            r_rdata <= r_tok_mem[{r_entry.bank, r_idx}];
        end
    end

    assign o_m_axis_tvalid = (r_state == BK_SEND);
    assign o_m_axis_tdata  = is_name ? r_rdata : '0;
    assign o_m_axis_tuser  = r_entry.kind;
    assign o_m_axis_tlast  = last_item;

endmodule

// ===== rtl/ascii_link_command_parser.sv =====
// top level of the link command parser: front end, command queue and back end
//
// slave stream: one received link byte per item, with the awaited chunk id beside it
// master stream: result items; a read command gives one item per name character with
// tlast on the final one, a chunk or end acknowledge gives a single item with tlast set
// a byte is taken whenever tready is high; a line end that matches a
// command puts one entry into a two-deep queue
// an idle back end pops the entry and sends its result; for a name it reads each
// character from the token store first and sends it after that read, so it does
// not fetch the next character before the current one is taken
// tready drops while the queue is full, or while the token bank the front end would
// fill is still queued or being sent
// a stalled receiver holds the output item stable; bytes keep being taken until the
// queue or the token banks run out
// reset empties the line, the queue and the output; the token store is not cleared
// and needs no clearing pass
module ascii_link_command_parser
    import alcp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,   // rx_byte[7:0], awaited_chunk[24:8], zero
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata,   // name_char[7:0]
    output logic [1:0]          o_m_axis_tuser,   // kind[1:0]
    output logic                o_m_axis_tlast
);

    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;
    t_cmd     push_cmd;
    t_cmd     head_cmd;
    t_tok_wr  tok_wr;
    t_release release_bank;

    alcp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_full        (q_full),
        .i_release       (release_bank),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .o_tok_wr        (tok_wr)
    );

    alcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    alcp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_cmd),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .i_tok_wr        (tok_wr),
        .o_release       (release_bank),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ===== rtl/alcp_checker.sv =====
// port checker for the link command parser and its bind to the top level
module alcp_checker
    import alcp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [M_DATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]          o_m_axis_tuser,
    input logic                o_m_axis_tlast
);

    logic [BYTE_W-1:0] out_char;

    assign out_char = o_m_axis_tdata[BYTE_W-1:0];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("output item changed while stalled");

    a_ack_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_NAME)
            |-> o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("acknowledge item not alone or carries data");

    a_name_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_NAME)
            |-> (out_char != CHAR_NUL) && !f_is_space(out_char))
        else $error("name item holds whitespace or nul");

    a_name_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast
            |=> !o_m_axis_tvalid || (o_m_axis_tuser == KIND_NAME))
        else $error("name run broken by another kind");

endmodule

bind ascii_link_command_parser alcp_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
// testbench for the link command parser: directed lines, then random lines, checked by fixed or predicted results
`timescale 1ns / 1ps

module tb_top;
    import alcp_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 60;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       last;
    } t_link_result;

    typedef struct packed {
        logic [7:0]         rx_byte;
        logic signed [16:0] awaited;
        logic               fixed;
        logic               fixed_has;
        t_kind              fixed_kind;
        logic [7:0]         fixed_char;
    } t_link_byte;

    typedef struct {
        string              text;
        int                 pad_n;
        logic [7:0]         pad_c;
        string              tail;
        logic [7:0]         term;
        logic signed [16:0] awaited;
        bit                 fixed;
        bit                 fixed_has;
        t_kind              fixed_kind;
        logic [7:0]         fixed_char;
    } t_line_row;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [S_DATA_W-1:0] s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [M_DATA_W-1:0] m_data;
    logic [1:0]          m_user;
    logic                m_last;

    int unsigned cycle_count = 0;
    int          err_count = 0;
    int          n_accepted = 0;
    int          stim_pos = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          ready_timer = 0;
    logic [15:0] ready_pat = 16'hFFFF;

    t_line_row    rows[$];
    t_link_byte   stim[$];
    t_link_byte   cur;
    logic [7:0]   lb[$];
    t_link_result pred_out[$];
    t_link_result exp_results[$];

    logic [7:0]  line_buf [LINE_CAP];
    int unsigned line_len = 0;
    bit          line_nul = 1'b0;

    ascii_link_command_parser dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RESET_CYCLES - 1) begin
            rst_n <= 1'b1;
        end
    end

    function automatic bit is_ws(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit line_starts(int unsigned len, string p);
        if (len < p.len()) return 1'b0;
        for (int k = 0; k < p.len(); k++) begin
            if (line_buf[k] != p[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_item(input logic [7:0] c, input logic signed [16:0] awaited);
        int unsigned len;
        int unsigned i;
        int unsigned mag;
        int          cnt;
        bit          neg;
        bit          got_digit;
        longint      val;
        pred_out.delete();
        if (c == CHAR_LF || c == CHAR_CR) begin
            if (line_len == 0) return;
            len = line_nul ? line_len - 1 : line_len;
            if (line_starts(len, "READ ")) begin
                i = READ_LEN;
                cnt = 0;
                while (i < len && is_ws(line_buf[i])) i++;
                while (i < len && !is_ws(line_buf[i]) && cnt < NAME_MAX) begin
                    pred_out.push_back('{kind: KIND_NAME, ch: line_buf[i], last: 1'b0});
                    cnt++;
                    i++;
                end
                if (cnt > 0) pred_out[cnt-1].last = 1'b1;
            end else if (line_starts(len, "ACK CHUNK ")) begin
                i = CHUNK_LEN;
                neg = 1'b0;
                got_digit = 1'b0;
                mag = 0;
                while (i < len && is_ws(line_buf[i])) i++;
                if (i < len && (line_buf[i] == CHAR_PLUS || line_buf[i] == CHAR_MINUS)) begin
                    neg = (line_buf[i] == CHAR_MINUS);
                    i++;
                end
                while (i < len && line_buf[i] >= "0" && line_buf[i] <= "9") begin
                    got_digit = 1'b1;
                    if (mag <= CHUNK_ID_MAX) mag = mag * 10 + (line_buf[i] - "0");
                    i++;
                end
                if (got_digit && mag <= CHUNK_ID_MAX) begin
                    val = neg ? -longint'(mag) : longint'(mag);
                    if (val == longint'(awaited)) begin
                        pred_out.push_back('{kind: KIND_CHUNK, ch: 8'h00, last: 1'b1});
                    end
                end
            end else if (len == END_LEN && line_starts(len, "ACK END")) begin
                pred_out.push_back('{kind: KIND_END, ch: 8'h00, last: 1'b1});
            end
            line_len = 0;
            line_nul = 1'b0;
        end else if (!line_nul && line_len < LINE_CAP) begin
            line_buf[line_len] = c;
            line_len++;
            if (c == CHAR_NUL) line_nul = 1'b1;
        end
    endtask

    function automatic logic signed [16:0] pick_awaited();
        case ($urandom_range(0, 7))
            0: return -17'sd1;
            1: return 17'sd65535;
            2: return 17'sd0;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [7:0] any_byte();
        logic [7:0] c;
        do c = $urandom_range(0, 255); while (c == CHAR_LF || c == CHAR_CR);
        return c;
    endfunction

    function automatic logic [7:0] tok_char();
        logic [7:0] c;
        c = $urandom_range(8'h21, 8'h7E);
        if ($urandom_range(0, 7) == 0) c = any_byte();
        return c;
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 3))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function automatic void push_str(string s);
        for (int k = 0; k < s.len(); k++) lb.push_back(s[k]);
    endfunction

    function automatic void push_item(logic [7:0] c, logic signed [16:0] aw);
        stim.push_back('{rx_byte: c, awaited: aw, fixed: 1'b0, fixed_has: 1'b0,
                         fixed_kind: KIND_NAME, fixed_char: 8'h00});
    endfunction

    function automatic void add_row(string text, logic [7:0] term, int awaited,
                                    bit fixed = 1'b0, bit has = 1'b0,
                                    t_kind kind = KIND_NAME, logic [7:0] ch = 8'h00,
                                    int pad_n = 0, logic [7:0] pad_c = 8'h00,
                                    string tail = "");
        t_line_row r;
        r.text       = text;
        r.pad_n      = pad_n;
        r.pad_c      = pad_c;
        r.tail       = tail;
        r.term       = term;
        r.awaited    = awaited;
        r.fixed      = fixed;
        r.fixed_has  = has;
        r.fixed_kind = kind;
        r.fixed_char = ch;
        rows.push_back(r);
    endfunction

    // sender: bursts with gaps, item held until taken
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_valid && s_ready) begin
                predict_item(cur.rx_byte, cur.awaited);
                if (cur.fixed) begin
                    if (cur.fixed_has) begin
                        exp_results.push_back('{kind: cur.fixed_kind, ch: cur.fixed_char,
                                                last: 1'b1});
                    end
                end else begin
                    foreach (pred_out[k]) exp_results.push_back(pred_out[k]);
                end
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (stim_pos < stim.size() && gap_left == 0) begin
                    cur = stim[stim_pos];
                    stim_pos++;
                    s_valid <= 1'b1;
                    s_data  <= {7'd0, cur.awaited, cur.rx_byte};
                    if (burst_left <= 1) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(1, 40);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 8);
                            gap_left   = $urandom_range(0, 6);
                        end
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // receiver: rotating ready pattern, reloaded now and then
    always @(posedge clk) begin
        if (ready_timer == 0) begin
            ready_timer <= $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: ready_pat <= 16'hFFFF;
                1: ready_pat <= 16'h00FF;
                default: ready_pat <= 16'($urandom) | 16'h0001;
            endcase
        end else begin
            ready_timer <= ready_timer - 1;
            ready_pat   <= {ready_pat[0], ready_pat[15:1]};
        end
        m_ready <= ready_pat[0];
    end

    always @(posedge clk) begin
        t_link_result e;
        if (rst_n && m_valid && m_ready) begin
            if (exp_results.size() == 0) begin
                $error("unexpected item: kind %0d, name_char %h, last %0d",
                       m_user, m_data, m_last);
                err_count++;
            end else begin
                e = exp_results.pop_front();
                if (m_user !== e.kind) begin
                    $error("kind: expected %0d, actual %0d", e.kind, m_user);
                    err_count++;
                end
                if (m_data !== e.ch) begin
                    $error("name_char: expected %h, actual %h", e.ch, m_data);
                    err_count++;
                end
                if (m_last !== e.last) begin
                    $error("last: expected %0d, actual %0d", e.last, m_last);
                    err_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int          rand_count;
        int          pick;
        int          n;
        int          k;
        int unsigned val;
        bit          neg;
        bit          has_digits;
        string       s;
        logic [7:0]  term;
        logic signed [16:0] aw;

        add_row("ACK END", CHAR_CR, 0, 1'b1, 1'b1, KIND_END);
        add_row("", CHAR_LF, 0, 1'b1);
        add_row("", CHAR_CR, 65535, 1'b1);
        add_row("READ X", CHAR_LF, -1, 1'b1, 1'b1, KIND_NAME, "X");
        add_row("READ \t  file_01.bin  trailing", CHAR_LF, 0);
        add_row("READ    ", CHAR_CR, 0, 1'b1);
        add_row("READ ", CHAR_LF, 0, .pad_n(66), .pad_c("a"));
        add_row("READ ", CHAR_LF, 0, .pad_n(3), .pad_c(8'hFF));
        add_row("ACK CHUNK 0", CHAR_LF, 0, 1'b1, 1'b1, KIND_CHUNK);
        add_row("ACK CHUNK 65535", CHAR_LF, 65535, 1'b1, 1'b1, KIND_CHUNK);
        add_row("ACK CHUNK 65536", CHAR_LF, 65535, 1'b1);
        add_row("ACK CHUNK -1", CHAR_CR, -1, 1'b1, 1'b1, KIND_CHUNK);
        add_row("ACK CHUNK  +42xyz", CHAR_LF, 42);
        add_row("ACK CHUNK -", CHAR_LF, 0, 1'b1);
        add_row("ACK CHUNK 7", CHAR_LF, 8, 1'b1);
        add_row("ACK CHUNK 99999999999", CHAR_LF, 65535, 1'b1);
        add_row("ACK CHUNK\t5", CHAR_LF, 5, 1'b1);
        add_row("ACK CHUNK 5", CHAR_CR, 5, 1'b1, 1'b1, KIND_CHUNK);
        add_row("ACK ENDX", CHAR_LF, 0, 1'b1);
        add_row("ACK END ", CHAR_LF, 0, 1'b1);
        add_row("ack end", CHAR_LF, 0, 1'b1);
        add_row("ACK END", CHAR_LF, 0, .pad_n(1), .pad_c(CHAR_NUL), .tail("ZZ"));
        add_row("READ ab", CHAR_LF, 0, .pad_n(1), .pad_c(CHAR_NUL), .tail("cd"));
        add_row("", CHAR_LF, 0, 1'b1, .pad_n(1), .pad_c(CHAR_NUL));
        add_row("READ ACK END", CHAR_CR, 0);

        foreach (rows[r]) begin
            for (int j = 0; j < rows[r].text.len(); j++) push_item(rows[r].text[j], pick_awaited());
            repeat (rows[r].pad_n) push_item(rows[r].pad_c, pick_awaited());
            for (int j = 0; j < rows[r].tail.len(); j++) push_item(rows[r].tail[j], pick_awaited());
            stim.push_back('{rx_byte: rows[r].term, awaited: rows[r].awaited,
                             fixed: rows[r].fixed, fixed_has: rows[r].fixed_has,
                             fixed_kind: rows[r].fixed_kind, fixed_char: rows[r].fixed_char});
        end

        rand_count = 0;
        while (rand_count < RANDOM_ITEMS) begin
            lb.delete();
            aw = pick_awaited();
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                push_str("READ ");
                repeat ($urandom_range(0, 3)) lb.push_back(ws_char());
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 12);
                repeat (n) lb.push_back(tok_char());
                if ($urandom_range(0, 3) == 0) push_str(" more");
            end else if (pick < 55) begin
                push_str("ACK CHUNK ");
                repeat ($urandom_range(0, 2)) lb.push_back(ws_char());
                neg = 1'b0;
                case ($urandom_range(0, 3))
                    0: lb.push_back(CHAR_PLUS);
                    1: begin
                        lb.push_back(CHAR_MINUS);
                        neg = 1'b1;
                    end
                    default: ;
                endcase
                case ($urandom_range(0, 9))
                    0: val = 0;
                    1: val = 1;
                    2: val = 65535;
                    3: val = 65536 + $urandom_range(0, 2000000);
                    default: val = $urandom_range(0, 65535);
                endcase
                has_digits = ($urandom_range(0, 11) != 0);
                if (has_digits) begin
                    if ($urandom_range(0, 4) == 0) push_str("00");
                    push_str($sformatf("%0d", val));
                end
                if ($urandom_range(0, 3) == 0) begin
                    lb.push_back(ws_char());
                    lb.push_back(tok_char());
                end
                if (has_digits && $urandom_range(0, 2) != 0) begin
                    if (!neg && val <= CHUNK_ID_MAX) aw = val;
                    else if (neg && val <= 1) aw = -val;
                end
            end else if (pick < 65) begin
                push_str("ACK END");
            end else if (pick < 78) begin
                // broken command: maybe cut short, maybe a flipped bit, then maybe junk
                case ($urandom_range(0, 2))
                    0: s = "READ ";
                    1: s = "ACK CHUNK ";
                    default: s = "ACK END";
                endcase
                push_str(s.substr(0, $urandom_range(0, s.len() - 1)));
                if ($urandom_range(0, 1) == 1) begin
                    k = $urandom_range(0, lb.size() - 1);
                    lb[k] = lb[k] ^ (8'h01 << $urandom_range(0, 7));
                end
                repeat ($urandom_range(0, 4)) lb.push_back(tok_char());
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 20)) lb.push_back(any_byte());
            end else if (pick >= 95) begin
                if ($urandom_range(0, 1) == 1) s = "ACK END";
                else s = "READ name";
                push_str(s);
                lb.insert($urandom_range(0, lb.size()), CHAR_NUL);
                push_str("zz");
            end
            foreach (lb[j]) push_item(lb[j], pick_awaited());
            term = ($urandom_range(0, 1) == 1) ? CHAR_CR : CHAR_LF;
            push_item(term, aw);
            if ($urandom_range(0, 5) == 0) begin
                push_item((term == CHAR_CR) ? CHAR_LF : CHAR_CR, pick_awaited());
            end
            rand_count += lb.size() + 1;
        end

        while (n_accepted < stim.size() || exp_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (exp_results.size() != 0) begin
            $error("items missing: %0d still expected", exp_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/alcp_pkg.sv
rtl/alcp_queue.sv
rtl/alcp_front.sv
rtl/alcp_back.sv
rtl/ascii_link_command_parser.sv
rtl/alcp_checker.sv
tb/sv/tb_top.sv
